FILE: rtl/kruskal_union_find_engine_macros.svh
// Assertion helpers used by the engine's top-level RTL
`ifndef KRUSKAL_UNION_FIND_ENGINE_MACROS_SVH
`define KRUSKAL_UNION_FIND_ENGINE_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define UFE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset
`define UFE_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: rtl/ufe_pkg.sv
package ufe_pkg;

   localparam int VERTEX_LIMIT = 1024;
   localparam int EDGE_LIMIT   = 4096;
   localparam int WEIGHT_WIDTH = 16;
   localparam int END_BITS     = 11;
   localparam int FIELD_W_BITS = 16;
   localparam int COST_BITS    = 32;
   localparam int SEQ_BITS     = 32;
   localparam int RANK_BITS    = 4;
   localparam logic [RANK_BITS-1:0] RANK_MAX = 4'd15;
   localparam logic [END_BITS-1:0] VERTEX_RESET = 11'd1024;

   // Request op codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_BAD_PUSH,
      CMD_POP,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [END_BITS-1:0]  end_a;
      logic [END_BITS-1:0]  end_b;
      logic signed [FIELD_W_BITS-1:0] weight;
   } ufe_req_type;

   typedef struct packed {
      logic [END_BITS-1:0]  edge_a;
      logic [END_BITS-1:0]  edge_b;
      logic signed [FIELD_W_BITS-1:0] edge_weight;
      logic                 accepted;
      logic signed [COST_BITS-1:0] total_cost;
      status_type           status;
   } ufe_rsp_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [END_BITS-1:0]  end_a;
      logic [END_BITS-1:0]  end_b;
      logic [FIELD_W_BITS-1:0] weight;
   } ufe_cmd_type;

   typedef struct packed {
      logic sweeping;
   } ufe_ctl_type;

   typedef enum logic [4:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_POP_TAKE,
      ST_DN_L,
      ST_DN_R,
      ST_DN_PICK,
      ST_DN_SEL,
      ST_UF_START,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_CMP_RD,
      ST_CMP_WR,
      ST_FIND_END,
      ST_RANK_B,
      ST_JOIN,
      ST_DONE
   } ufe_state_type;

endpackage

FILE: rtl/ufe_ram.sv
module ufe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write one entry, read one entry a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ufe_queue.sv
module ufe_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ufe_pkg::ufe_cmd_type wdata,
   output logic                 space,
   input  logic                 pop,
   output logic                 avail,
   output ufe_pkg::ufe_cmd_type rdata
);
   import ufe_pkg::*;

   ufe_cmd_type slot_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  fill_ff, fill_in;

   assign space = (fill_ff != 2'd2);
   assign avail = (fill_ff != 2'd0);
   assign rdata = slot_ff[rptr_ff];

   // advance pointers and fill level
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // store the incoming command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/ufe_front.sv
module ufe_front #(
   parameter int NVW = 11
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ufe_pkg::ufe_req_type req_data,
   input  logic [NVW-1:0]       live_nv,
   input  ufe_pkg::ufe_ctl_type ctl,
   input  logic                 q_space,
   output logic                 q_push,
   output ufe_pkg::ufe_cmd_type q_wdata
);
   import ufe_pkg::*;

   logic bad_end;

   // hold off while the queue is full or the back end sweeps the tables
   assign req_ready = q_space && !ctl.sweeping;
   assign q_push    = req_valid && req_ready;

   // classify the transaction
   always_comb begin
      bad_end = (req_data.end_a == '0) || (32'(req_data.end_a) > 32'(live_nv)) ||
                (req_data.end_b == '0) || (32'(req_data.end_b) > 32'(live_nv));
      q_wdata.end_a  = req_data.end_a;
      q_wdata.end_b  = req_data.end_b;
      q_wdata.weight = req_data.weight;
      unique case (req_data.op)
         OP_PUSH:  q_wdata.kind = bad_end ? CMD_BAD_PUSH : CMD_PUSH;
         OP_POP:   q_wdata.kind = CMD_POP;
         OP_CLEAR: q_wdata.kind = CMD_CLEAR;
         default:  q_wdata.kind = CMD_NOP;
      endcase
   end

endmodule

FILE: rtl/ufe_back.sv
module ufe_back #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096,
   parameter int WEIGHT_BITS  = 16,
   parameter int NVW          = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_avail,
   output logic                 q_pop,
   input  ufe_pkg::ufe_cmd_type q_rdata,
   input  logic [NVW-1:0]       live_nv,
   output ufe_pkg::ufe_ctl_type ctl,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ufe_pkg::ufe_rsp_type rsp_data
);
   import ufe_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int CW = EW + 1;
   localparam int SB = SEQ_BITS;
   localparam int EB = SB + WEIGHT_BITS + 2 * END_BITS;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_EDGES);
   localparam logic [VW-1:0] LAST_VERTEX = VW'(MAX_VERTICES - 1);

   ufe_state_type state_ff, state_in;
   logic              reply_ff, reply_in;
   logic [VW-1:0]     sweep_ff, sweep_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SB-1:0]     seq_ff, seq_in;
   logic [COST_BITS-1:0] cost_ff, cost_in;
   logic [EW-1:0]     idx_ff, idx_in;
   logic [EW-1:0]     cidx_ff, cidx_in;
   logic [EB-1:0]     item_ff, item_in;
   logic [EB-1:0]     child_ff, child_in;
   logic [EB-1:0]     pop_ff, pop_in;
   logic [VW-1:0]     root_ff, root_in;
   logic [VW-1:0]     cur_ff, cur_in;
   logic [VW-1:0]     ra_ff, ra_in;
   logic              phase_ff, phase_in;
   logic [RANK_BITS-1:0] rank_a_ff, rank_a_in;
   ufe_rsp_type       res_ff, res_in;
   ufe_rsp_type       rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              h_we;
   logic [EW-1:0]     h_waddr, h_raddr;
   logic [EB-1:0]     h_wdata, h_rdata;
   logic              p_we;
   logic [VW-1:0]     p_waddr, p_raddr, p_wdata, p_rdata;
   logic              r_we;
   logic [VW-1:0]     r_waddr, r_raddr;
   logic [RANK_BITS-1:0] r_wdata, r_rdata;

   logic [CW-1:0]     lchild;
   logic [CW:0]       rchild;
   logic              out_free;
   logic              pop_bad;
   logic [END_BITS-1:0] pop_a, pop_b;

   // field access on a heap entry
   function automatic logic [WEIGHT_BITS-1:0] ent_w(input logic [EB-1:0] e);
      return e[SB +: WEIGHT_BITS];
   endfunction

   function automatic logic [END_BITS-1:0] ent_a(input logic [EB-1:0] e);
      return e[SB + WEIGHT_BITS + END_BITS +: END_BITS];
   endfunction

   function automatic logic [END_BITS-1:0] ent_b(input logic [EB-1:0] e);
      return e[SB + WEIGHT_BITS +: END_BITS];
   endfunction

   // lighter weight first, earlier push on a tie
   function automatic logic ent_less(input logic [EB-1:0] x, input logic [EB-1:0] y);
      logic signed [WEIGHT_BITS-1:0] wx;
      logic signed [WEIGHT_BITS-1:0] wy;
      wx = $signed(ent_w(x));
      wy = $signed(ent_w(y));
      return (wx < wy) || ((wx == wy) && (x[SB-1:0] < y[SB-1:0]));
   endfunction

   ufe_ram #(.WIDTH(EB), .DEPTH(MAX_EDGES)) u_heap (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   ufe_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_parent (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rdata)
   );

   ufe_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_VERTICES)) u_rank (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(r_raddr), .rdata(r_rdata)
   );

   assign lchild   = CW'({idx_ff, 1'b1});
   assign rchild   = (CW + 1)'({idx_ff, 1'b1}) + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop_a    = ent_a(pop_ff);
   assign pop_b    = ent_b(pop_ff);
   assign pop_bad  = (pop_a == '0) || (32'(pop_a) > 32'(live_nv)) ||
                     (pop_b == '0) || (32'(pop_b) > 32'(live_nv));
   assign ctl.sweeping = (state_ff == ST_SWEEP);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == LAST_VERTEX) begin
               state_in = reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_avail) begin
               unique case (q_rdata.kind)
                  CMD_CLEAR: state_in = ST_SWEEP;
                  CMD_PUSH:  state_in = (count_ff == FULL_COUNT) ? ST_DONE : ST_UP_CHK;
                  CMD_POP:   state_in = (count_ff == '0) ? ST_DONE : ST_POP_ROOT;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_UP_CHK:   state_in = (idx_ff == '0) ? ST_DONE : ST_UP_CMP;
         ST_UP_CMP:   state_in = ent_less(item_ff, h_rdata) ? ST_UP_CHK : ST_DONE;
         ST_POP_ROOT: state_in = ST_POP_LAST;
         ST_POP_LAST: state_in = ST_POP_TAKE;
         ST_POP_TAKE: state_in = ST_DN_L;
         ST_DN_L:     state_in = (lchild < count_ff) ? ST_DN_R : ST_UF_START;
         ST_DN_R:     state_in = (rchild < {1'b0, count_ff}) ? ST_DN_PICK : ST_DN_SEL;
         ST_DN_PICK:  state_in = ST_DN_SEL;
         ST_DN_SEL:   state_in = ent_less(child_ff, item_ff) ? ST_DN_L : ST_UF_START;
         ST_UF_START: state_in = pop_bad ? ST_DONE : ST_FIND_RD;
         ST_FIND_RD:  state_in = ST_FIND_CHK;
         ST_FIND_CHK: state_in = (p_rdata == root_ff) ? ST_CMP_RD : ST_FIND_RD;
         ST_CMP_RD:   state_in = (cur_ff == root_ff) ? ST_FIND_END : ST_CMP_WR;
         ST_CMP_WR:   state_in = ST_CMP_RD;
         ST_FIND_END: begin
            if (!phase_ff) begin
               state_in = ST_FIND_RD;
            end else begin
               state_in = (ra_ff == root_ff) ? ST_DONE : ST_RANK_B;
            end
         end
         ST_RANK_B:   state_in = ST_JOIN;
         ST_JOIN:     state_in = ST_DONE;
         ST_DONE:     state_in = out_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      reply_in  = reply_ff;
      sweep_in  = sweep_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      cost_in   = cost_ff;
      idx_in    = idx_ff;
      cidx_in   = cidx_ff;
      item_in   = item_ff;
      child_in  = child_ff;
      pop_in    = pop_ff;
      root_in   = root_ff;
      cur_in    = cur_ff;
      ra_in     = ra_ff;
      phase_in  = phase_ff;
      rank_a_in = rank_a_ff;
      res_in    = res_ff;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      q_pop     = 1'b0;
      h_we      = 1'b0;
      h_waddr   = idx_ff;
      h_wdata   = item_ff;
      h_raddr   = '0;
      p_we      = 1'b0;
      p_waddr   = sweep_ff;
      p_wdata   = sweep_ff;
      p_raddr   = root_ff;
      r_we      = 1'b0;
      r_waddr   = sweep_ff;
      r_wdata   = '0;
      r_raddr   = ra_ff;

      // drop the result once taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_SWEEP: begin
            // restore identity parents and zero ranks
            p_we     = 1'b1;
            r_we     = 1'b1;
            sweep_in = sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            if (q_avail) begin
               q_pop  = 1'b1;
               res_in = '0;
               res_in.status = STS_OK;
               unique case (q_rdata.kind)
                  CMD_CLEAR: begin
                     reply_in = 1'b1;
                     sweep_in = '0;
                     count_in = '0;
                     seq_in   = '0;
                     cost_in  = '0;
                  end
                  CMD_BAD_PUSH: res_in.status = STS_RANGE;
                  CMD_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        res_in.status = STS_FULL;
                     end else begin
                        item_in  = {q_rdata.end_a, q_rdata.end_b,
                                    WEIGHT_BITS'(q_rdata.weight), seq_ff};
                        seq_in   = seq_ff + 1'b1;
                        idx_in   = EW'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STS_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_UP_CHK: begin
            // place at the root, or fetch the parent
            h_raddr = EW'((idx_ff - 1'b1) >> 1);
            if (idx_ff == '0) begin
               h_we = 1'b1;
            end
         end
         ST_UP_CMP: begin
            h_we = 1'b1;
            if (ent_less(item_ff, h_rdata)) begin
               h_wdata = h_rdata;
               idx_in  = EW'((idx_ff - 1'b1) >> 1);
            end
         end
         ST_POP_ROOT: h_raddr = '0;
         ST_POP_LAST: begin
            pop_in   = h_rdata;
            h_raddr  = EW'(count_ff - 1'b1);
            count_in = count_ff - 1'b1;
         end
         ST_POP_TAKE: begin
            item_in = h_rdata;
            idx_in  = '0;
         end
         ST_DN_L: begin
            h_raddr = EW'(lchild);
            if (!(lchild < count_ff)) begin
               h_we = 1'b1;
            end
         end
         ST_DN_R: begin
            child_in = h_rdata;
            cidx_in  = EW'(lchild);
            h_raddr  = EW'(rchild);
         end
         ST_DN_PICK: begin
            if (ent_less(h_rdata, child_ff)) begin
               child_in = h_rdata;
               cidx_in  = EW'(rchild);
            end
         end
         ST_DN_SEL: begin
            h_we = 1'b1;
            if (ent_less(child_ff, item_ff)) begin
               h_wdata = child_ff;
               idx_in  = cidx_ff;
            end
         end
         ST_UF_START: begin
            res_in.edge_a      = pop_a;
            res_in.edge_b      = pop_b;
            res_in.edge_weight = FIELD_W_BITS'(ent_w(pop_ff));
            if (pop_bad) begin
               res_in.status = STS_RANGE;
            end else begin
               root_in  = VW'(pop_a - 1'b1);
               cur_in   = VW'(pop_a - 1'b1);
               phase_in = 1'b0;
            end
         end
         ST_FIND_RD: p_raddr = root_ff;
         ST_FIND_CHK: begin
            if (p_rdata != root_ff) begin
               root_in = p_rdata;
            end
         end
         ST_CMP_RD: p_raddr = cur_ff;
         ST_CMP_WR: begin
            // point the node at the root and move on
            p_we    = 1'b1;
            p_waddr = cur_ff;
            p_wdata = root_ff;
            cur_in  = p_rdata;
         end
         ST_FIND_END: begin
            if (!phase_ff) begin
               ra_in    = root_ff;
               root_in  = VW'(pop_b - 1'b1);
               cur_in   = VW'(pop_b - 1'b1);
               phase_in = 1'b1;
            end else begin
               r_raddr = ra_ff;
            end
         end
         ST_RANK_B: begin
            rank_a_in = r_rdata;
            r_raddr   = root_ff;
         end
         ST_JOIN: begin
            // union by rank, the second root is in root_ff
            p_we = 1'b1;
            if (rank_a_ff > r_rdata) begin
               p_waddr = root_ff;
               p_wdata = ra_ff;
            end else if (rank_a_ff < r_rdata) begin
               p_waddr = ra_ff;
               p_wdata = root_ff;
            end else begin
               p_waddr = root_ff;
               p_wdata = ra_ff;
               r_we    = 1'b1;
               r_waddr = ra_ff;
               r_wdata = (rank_a_ff == RANK_MAX) ? RANK_MAX : rank_a_ff + 1'b1;
            end
            cost_in = cost_ff + COST_BITS'($signed(ent_w(pop_ff)));
            res_in.accepted = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in            = res_ff;
               rsp_in.total_cost = cost_ff;
               rsp_valid_in      = 1'b1;
               reply_in          = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         reply_ff     <= 1'b0;
         sweep_ff     <= '0;
         count_ff     <= '0;
         seq_ff       <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reply_ff     <= reply_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         seq_ff       <= seq_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      cidx_ff   <= cidx_in;
      item_ff   <= item_in;
      child_ff  <= child_in;
      pop_ff    <= pop_in;
      root_ff   <= root_in;
      cur_ff    <= cur_in;
      ra_ff     <= ra_in;
      phase_ff  <= phase_in;
      rank_a_ff <= rank_a_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

endmodule

FILE: rtl/kruskal_union_find_engine.sv
// Push: the new edge climbs the heap, reading and comparing its parent per level.
// Pop: a sift-down reads the left and right child and picks per heap level, then a
// find and compress pass runs for each endpoint, and a union by rank follows.
// Clear: one cycle per vertex (MAX_VERTICES) to sweep the parent and rank RAMs.
// Reset: the same sweep runs, no request accepted meanwhile.
// A two-entry queue lets requests arrive while the back end still works.
`include "kruskal_union_find_engine_macros.svh"

module kruskal_union_find_engine #(
   parameter int MAX_VERTICES = ufe_pkg::VERTEX_LIMIT,
   parameter int MAX_EDGES    = ufe_pkg::EDGE_LIMIT,
   parameter int WEIGHT_BITS  = ufe_pkg::WEIGHT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ufe_pkg::ufe_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ufe_pkg::ufe_rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ufe_pkg::END_BITS-1:0]      csr_data
);
   import ufe_pkg::*;

   localparam int NVW = $clog2(MAX_VERTICES + 1);

   logic [END_BITS-1:0] vcount_ff;
   logic [NVW-1:0]      live_nv;
   ufe_ctl_type         ctl;
   logic                q_push, q_space, q_pop, q_avail;
   ufe_cmd_type         q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   // hold the vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VERTEX_RESET;
      end else if (csr_valid) begin
         vcount_ff <= csr_data;
      end
   end

   // clamp the vertex count to its usable range
   always_comb begin
      if (vcount_ff == '0) begin
         live_nv = NVW'(1);
      end else if (32'(vcount_ff) > 32'(MAX_VERTICES)) begin
         live_nv = NVW'(MAX_VERTICES);
      end else begin
         live_nv = NVW'(vcount_ff);
      end
   end

   ufe_front #(.NVW(NVW)) u_front (
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .live_nv(live_nv), .ctl(ctl), .q_space(q_space), .q_push(q_push),
      .q_wdata(q_wdata)
   );

   ufe_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .wdata(q_wdata),
      .space(q_space), .pop(q_pop), .avail(q_avail), .rdata(q_rdata)
   );

   ufe_back #(
      .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
      .WEIGHT_BITS(WEIGHT_BITS), .NVW(NVW)
   ) u_back (
      .clock(clock), .reset(reset), .q_avail(q_avail), .q_pop(q_pop),
      .q_rdata(q_rdata), .live_nv(live_nv), .ctl(ctl),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   `UFE_NEVER(a_queue_overflow, q_push && !q_space, "command queue overflow")
   `UFE_NEVER(a_pop_empty, q_pop && !q_avail, "command queue underflow")
   `UFE_ASSERT(a_sweep_blocks, ctl.sweeping |-> !req_ready, "request taken during sweep")
   `UFE_ASSERT(a_accept_ok, rsp_valid && rsp_data.accepted |-> rsp_data.status == STS_OK, "accepted edge with bad status")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ufe_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 20000;
   localparam int         SWEEP_WAIT = VERTEX_LIMIT + 100;

   typedef struct packed {
      logic [END_BITS-1:0]     a;
      logic [END_BITS-1:0]     b;
      logic [FIELD_W_BITS-1:0] w;
   } pend_edge_type;

   typedef struct {
      bit                  cfg_on;
      logic [END_BITS-1:0] cfg_val;
      ufe_req_type         req;
      bit                  fixed;
      ufe_rsp_type         rsp;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ufe_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   ufe_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [END_BITS-1:0] csr_data;

   // Forest and pending-edge shadow state
   logic [9:0]          forest_parent [VERTEX_LIMIT];
   logic [3:0]          forest_rank [VERTEX_LIMIT];
   pend_edge_type       pending_edges [$];
   logic [31:0]         tree_cost;
   logic [END_BITS-1:0] vertex_count;

   ufe_rsp_type rsp_expected [$];
   dir_row_type dir_tab [$];
   int          mismatches;
   int          quiet_cycles;
   bit          calm;
   int          rsp_stall;

   kruskal_union_find_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int live_count();
      if (vertex_count == 0) return 1;
      if (vertex_count > VERTEX_LIMIT) return VERTEX_LIMIT;
      return vertex_count;
   endfunction

   function automatic void clear_forest();
      for (int i = 0; i < VERTEX_LIMIT; i++) begin
         forest_parent[i] = 10'(i);
         forest_rank[i] = '0;
      end
      pending_edges.delete();
      tree_cost = '0;
   endfunction

   // Find the root, then point every node on the path straight at it
   function automatic logic [9:0] find_root(logic [9:0] v);
      logic [9:0] r;
      logic [9:0] c;
      logic [9:0] nx;
      r = v;
      while (forest_parent[r] != r) r = forest_parent[r];
      c = v;
      while (c != r) begin
         nx = forest_parent[c];
         forest_parent[c] = r;
         c = nx;
      end
      return r;
   endfunction

   function automatic ufe_rsp_type predict_mst(ufe_req_type rq);
      ufe_rsp_type   rs;
      int            nv;
      int            best;
      pend_edge_type e;
      logic [9:0]    ra;
      logic [9:0]    rb;
      rs = '0;
      rs.status = STS_OK;
      nv = live_count();
      case (rq.op)
         OP_PUSH: begin
            if (rq.end_a == 0 || rq.end_a > nv || rq.end_b == 0 || rq.end_b > nv)
               rs.status = STS_RANGE;
            else if (pending_edges.size() >= EDGE_LIMIT)
               rs.status = STS_FULL;
            else
               pending_edges.insert(pending_edges.size(), '{rq.end_a, rq.end_b, rq.weight});
         end
         OP_POP: begin
            if (pending_edges.size() == 0) begin
               rs.status = STS_EMPTY;
            end else begin
               // Lightest edge wins; the earliest pushed wins a tie
               best = 0;
               for (int i = 1; i < pending_edges.size(); i++)
                  if ($signed(pending_edges[i].w) < $signed(pending_edges[best].w))
                     best = i;
               e = pending_edges[best];
               pending_edges.delete(best);
               rs.edge_a = e.a;
               rs.edge_b = e.b;
               rs.edge_weight = e.w;
               if (e.a == 0 || e.a > nv || e.b == 0 || e.b > nv) begin
                  rs.status = STS_RANGE;
               end else begin
                  ra = find_root(10'(e.a - 1));
                  rb = find_root(10'(e.b - 1));
                  if (ra != rb) begin
                     if (forest_rank[ra] > forest_rank[rb]) begin
                        forest_parent[rb] = ra;
                     end else if (forest_rank[ra] < forest_rank[rb]) begin
                        forest_parent[ra] = rb;
                     end else begin
                        forest_parent[rb] = ra;
                        if (forest_rank[ra] != RANK_MAX) forest_rank[ra]++;
                     end
                     tree_cost = tree_cost + {{16{e.w[15]}}, e.w};
                     rs.accepted = 1'b1;
                  end
               end
            end
         end
         OP_CLEAR: clear_forest();
         default: ;
      endcase
      rs.total_cost = tree_cost;
      return rs;
   endfunction

   function automatic dir_row_type row(bit cfg_on, logic [10:0] cfg_val, logic [1:0] op,
                                       logic [10:0] a, logic [10:0] b, logic [15:0] w,
                                       bit fixed, logic [10:0] ea, logic [10:0] eb,
                                       logic [15:0] ew, logic acc, logic [31:0] cost,
                                       status_type st);
      dir_row_type r;
      r.cfg_on = cfg_on;
      r.cfg_val = cfg_val;
      r.req = '{op, a, b, w};
      r.fixed = fixed;
      r.rsp = '{ea, eb, ew, acc, cost, st};
      return r;
   endfunction

   // Append one row to the directed table
   function automatic void add_row(dir_row_type r);
      dir_tab.insert(dir_tab.size(), r);
   endfunction

   // Hold valid until the transaction is taken, then log its expectation
   task automatic send_req(ufe_req_type rq, bit fixed, ufe_rsp_type fixed_rsp);
      ufe_rsp_type p;
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      p = predict_mst(rq);
      rsp_expected.insert(rsp_expected.size(), fixed ? fixed_rsp : p);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
   endtask

   // Write the vertex count only once the engine has gone quiet
   task automatic write_count(logic [END_BITS-1:0] v);
      drain();
      repeat (SWEEP_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vertex_count = v;
   endtask

   function automatic ufe_req_type random_req(int push_pct, int pop_pct);
      ufe_req_type rq;
      int          pick;
      int          nv;
      nv = live_count();
      pick = $urandom_range(0, 99);
      rq.end_a = 11'($urandom_range(1, nv));
      rq.end_b = 11'($urandom_range(1, nv));
      if ($urandom_range(0, 1) == 0)
         rq.weight = 16'($signed($urandom_range(0, 15)) - 8);
      else
         rq.weight = 16'($urandom);
      if (pick < push_pct) begin
         rq.op = OP_PUSH;
         // Toss in a stray endpoint now and then
         if ($urandom_range(0, 19) == 0) rq.end_a = 11'($urandom);
         if ($urandom_range(0, 19) == 0) rq.end_b = 11'($urandom);
      end else if (pick < push_pct + pop_pct) begin
         rq.op = OP_POP;
         rq.end_a = 11'($urandom);
         rq.end_b = 11'($urandom);
      end else if (pick < 99) begin
         rq.op = OP_CLEAR;
      end else begin
         rq.op = OP_UNUSED;
      end
      return rq;
   endfunction

   task automatic run_phase(logic [END_BITS-1:0] v, int n, bit hold_mid);
      write_count(v);
      for (int i = 0; i < n; i++) begin
         if (hold_mid && i == n / 2) drain();
         maybe_gap();
         send_req(random_req(55, 43), 1'b0, '0);
      end
   endtask

   // Randomly stall the result side in short bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= (rsp_stall == 1);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_stall <= $urandom_range(1, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      ufe_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = rsp_expected.pop_front();
            if (rsp_data.edge_a !== e.edge_a || rsp_data.edge_b !== e.edge_b ||
                rsp_data.edge_weight !== e.edge_weight ||
                rsp_data.accepted !== e.accepted ||
                rsp_data.total_cost !== e.total_cost || rsp_data.status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      mismatches = 0;
      calm = 1'b0;
      vertex_count = VERTEX_RESET;
      clear_forest();

      add_row(row(0, 0, OP_POP, 0, 0, 0, 1, 0, 0, 0, 0, 0, STS_EMPTY));
      add_row(row(0, 0, OP_PUSH, 0, 5, 1, 1, 0, 0, 0, 0, 0, STS_RANGE));
      add_row(row(0, 0, OP_PUSH, 2047, 2047, 1, 1, 0, 0, 0, 0, 0, STS_RANGE));
      add_row(row(0, 0, OP_PUSH, 1025, 1, 1, 1, 0, 0, 0, 0, 0, STS_RANGE));
      add_row(row(0, 0, OP_PUSH, 1, 1024, 16'h7FFF, 1, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_PUSH, 1024, 2, 16'h8000, 1, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_PUSH, 3, 3, 5, 1, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_PUSH, 2, 1, 16'h8000, 1, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_UNUSED, 2047, 2047, 16'hFFFF, 0, 0, 0, 0, 0, 0,
                  STS_OK));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 1, 1024, 2, 16'h8000, 1,
                  32'hFFFF8000, STS_OK));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 1, 2, 1, 16'h8000, 1,
                  32'hFFFF0000, STS_OK));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 1, 0, 0, 0, 0, 32'hFFFF0000,
                  STS_EMPTY));
      add_row(row(0, 0, OP_PUSH, 900, 901, 7, 0, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_PUSH, 4, 5, 100, 0, 0, 0, 0, 0, 0, STS_OK));
      // Shrink below a pending edge: the stale edge pops out of range
      add_row(row(1, 8, OP_POP, 0, 0, 0, 1, 900, 901, 7, 0, 32'hFFFF0000,
                  STS_RANGE));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, STS_OK));
      // A count of zero acts as one vertex
      add_row(row(1, 0, OP_PUSH, 1, 1, 3, 0, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_PUSH, 2, 1, 3, 1, 0, 0, 0, 0, 32'hFFFF0064,
                  STS_RANGE));
      // An oversized count saturates at the vertex limit
      add_row(row(1, 2047, OP_PUSH, 1024, 1, 16'hFFFF, 0, 0, 0, 0, 0, 0,
                  STS_OK));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_CLEAR, 0, 0, 0, 1, 0, 0, 0, 0, 0, STS_OK));
      add_row(row(0, 0, OP_POP, 0, 0, 0, 1, 0, 0, 0, 0, 0, STS_EMPTY));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].cfg_on) write_count(dir_tab[i].cfg_val);
         maybe_gap();
         send_req(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].rsp);
      end

      // Load a batch of edges, then pop some and clear
      write_count(VERTEX_RESET);
      for (int i = 0; i < 200; i++) begin
         maybe_gap();
         send_req(random_req(100, 0), 1'b0, '0);
      end
      for (int i = 0; i < 20; i++) send_req(random_req(0, 100), 1'b0, '0);
      send_req('{OP_CLEAR, 11'd0, 11'd0, 16'd0}, 1'b0, '0);

      // Random phases over several vertex counts
      run_phase(11'd1024, 220, 1'b0);
      run_phase(11'd16, 220, 1'b1);
      run_phase(11'd3, 180, 1'b0);
      run_phase(11'd200, 220, 1'b0);
      run_phase(11'd0, 120, 1'b0);
      run_phase(11'd2047, 220, 1'b0);
      run_phase(11'd1, 120, 1'b0);
      calm = 1'b1;
      run_phase(11'd64, 250, 1'b0);

      drain();
      repeat (SWEEP_WAIT) @(posedge clock);
      if (mismatches == 0 && rsp_expected.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/ufe_pkg.sv
rtl/ufe_ram.sv
rtl/ufe_queue.sv
rtl/ufe_front.sv
rtl/ufe_back.sv
rtl/kruskal_union_find_engine.sv
sim/testbench.sv
